@@ hw/rtl/isqrt32_pkg.sv @@
// Shared constants for the 32-bit integer square root pipeline.
// No dependencies; imported by isqrt32_stage and integer_square_root_32.
package isqrt32_pkg;

  // Field widths on the stream ports
  localparam int RADICAND_W = 32;
  localparam int ROOT_W     = 16;

  // Radicand bits consumed per recurrence step
  localparam int PAIR_W     = 2;

endpackage

@@ hw/rtl/integer_square_root_32.sv @@
// Pipelined integer square root: root = floor(sqrt(radicand)) for a 32-bit
// unsigned radicand. One pipeline stage settles each root bit, and a new
// transaction is taken every cycle unless back-pressure has stalled the input.
// Each stage has its own valid bit and holds under back-pressure, so a stall
// at the output only fills bubbles upstream; nothing is lost or repeated.
// The recurrence reads the low 2*ROOT_BITS radicand bits (zero-extended when
// ROOT_BITS is above 16); the root is reported in 16 bits.
// Depends on isqrt32_pkg and isqrt32_stage.
module integer_square_root_32 #(
  parameter int ROOT_BITS = 16  // 1..32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [isqrt32_pkg::RADICAND_W-1:0] s_axis_tdata,   // [31:0] radicand
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [isqrt32_pkg::ROOT_W-1:0]     m_axis_tdata    // [15:0] root
);
  import isqrt32_pkg::*;

  localparam int RB = ROOT_BITS;
  localparam int RW = RB + 4;

  logic            vld   [0:RB];
  logic            rdy   [0:RB];
  logic [RW-1:0]   rem   [0:RB];
  logic [RB:0]     twice [0:RB];
  logic [2*RB-1:0] rad   [0:RB];
  logic [63:0]     rad_ext;
  logic [63:0]     root_ext;

  // Fit radicand to the recurrence width
  assign rad_ext = 64'(s_axis_tdata);

  assign vld[0]   = s_axis_tvalid;
  assign rem[0]   = '0;
  assign twice[0] = '0;
  assign rad[0]   = rad_ext[2*RB-1:0];
  assign s_axis_tready = rdy[0];

  // One stage per root bit
  for (genvar i = 0; i < RB; i++) begin : g_stage
    isqrt32_stage #(
      .RB   (RB),
      .STEP (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_rem    (rem[i]),
      .in_twice  (twice[i]),
      .in_rad    (rad[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_rem   (rem[i+1]),
      .out_twice (twice[i+1]),
      .out_rad   (rad[i+1])
    );
  end

  // Root is half the final doubled root
  assign root_ext      = 64'(twice[RB][RB:1]);
  assign m_axis_tvalid = vld[RB];
  assign rdy[RB]       = m_axis_tready;
  assign m_axis_tdata  = root_ext[ROOT_W-1:0];

`ifndef SYNTH
  // Empty output stage means the whole chain can advance
  a_ready_when_tail_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[RB] |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  // Accepted transaction lands in the first stage
  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[1])
    else $error("accepted transaction missing from first stage");

  // Nothing valid right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !vld[1])
    else $error("valid bits set after reset");

  // Remainder never exceeds doubled root at the output
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[RB] |-> rem[RB] <= RW'(twice[RB]))
    else $error("remainder out of range");
`endif

endmodule

@@ hw/rtl/isqrt32_stage.sv @@
// One registered step of the restoring square root recurrence.
// Depends on isqrt32_pkg (PAIR_W). Instantiated once per root bit by the top level.
module isqrt32_stage #(
  parameter int RB   = 16,  // root bits in the whole recurrence
  parameter int STEP = 0    // which root bit this stage settles, MSB first
) (
  input  logic                clk,
  input  logic                rst,
  // upstream side
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [RB+3:0]       in_rem,
  input  logic [RB:0]         in_twice,
  input  logic [2*RB-1:0]     in_rad,
  // downstream side
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RB+3:0]       out_rem,
  output logic [RB:0]         out_twice,
  output logic [2*RB-1:0]     out_rad
);
  import isqrt32_pkg::*;

  localparam int RW  = RB + 4;
  localparam int POS = PAIR_W * (RB - 1 - STEP);

  logic [RB:0]   twice_sh;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] diff;
  logic          take;
  logic [RW-1:0] rem_next;
  logic [RB:0]   twice_next;

  // Shift in next radicand pair, trial subtract (doubled root + 1)
  always_comb begin
    twice_sh   = {in_twice[RB-1:0], 1'b0};
    rem_sh     = {in_rem[RW-PAIR_W-1:0], in_rad[POS +: PAIR_W]};
    take       = RW'(twice_sh) < rem_sh;
    diff       = rem_sh - RW'(twice_sh) - RW'(1);
    rem_next   = take ? diff : rem_sh;
    twice_next = take ? (twice_sh + (RB+1)'(2)) : twice_sh;
  end

  // Stage moves when empty or when downstream takes its transaction
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem   <= rem_next;
      out_twice <= twice_next;
      out_rad   <= in_rad;
    end
  end

endmodule
